### rtl/core/tnb_pkg.sv
// Shared types and constants for the contact tangent basis datapath.
package tnb_pkg;
	localparam int FB = 14;
	localparam int NW = 16;
	localparam int SW = 2 * NW;
	localparam int EW = 68;
	localparam int MW = FB + 1;
	localparam int NCELL = FB + 1;
	localparam int BW = $clog2(MW + 1);

	typedef struct packed {
		logic signed [EW-1:0] e;
		logic signed [EW-1:0] p;
		logic [MW-1:0] m;
	} lane_t;

	typedef struct packed {
		logic vld;
		logic signed [NW-1:0] x;
		logic signed [NW-1:0] y;
		logic signed [NW-1:0] z;
		logic sel;
		logic deg;
		logic [SW-1:0] s;
		lane_t lz;
		lane_t lo;
	} beat_t;
endpackage

### rtl/core/tnb_front.sv
// Front end: axis choice, squares, square sum and initial residuals.
module tnb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  logic signed [tnb_pkg::NW-1:0] x,
	input  logic signed [tnb_pkg::NW-1:0] y,
	input  logic signed [tnb_pkg::NW-1:0] z,
	output tnb_pkg::beat_t beat
);
	import tnb_pkg::*;

	logic vld_s1, vld_q, sel_s1;
	logic signed [NW-1:0] x_s1, y_s1, z_s1;
	logic [SW-1:0] sqz_s1, sqo_s1;
	logic signed [NW:0] ax, ay;
	logic signed [NW-1:0] o;
	logic signed [SW-1:0] sqz, sqo;
	logic [SW-1:0] s;
	beat_t nxt, beat_q;

	assign ax = x[NW-1] ? -{x[NW-1], x} : {x[NW-1], x};
	assign ay = y[NW-1] ? -{y[NW-1], y} : {y[NW-1], y};
	assign o = (ax > ay) ? x : y;
	assign sqz = z * z;
	assign sqo = o * o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			y_s1 <= y;
			z_s1 <= z;
			sel_s1 <= ax > ay;
			sqz_s1 <= unsigned'(sqz);
			sqo_s1 <= unsigned'(sqo);
		end
	end

	assign s = sqz_s1 + sqo_s1;

	always_comb begin
		nxt = '0;
		nxt.x = x_s1;
		nxt.y = y_s1;
		nxt.z = z_s1;
		nxt.sel = sel_s1;
		nxt.deg = (s == '0);
		nxt.s = s;
		nxt.lz.e = (signed'({{(EW-SW){1'b0}}, sqz_s1}) <<< (2 * FB + 2))
			- signed'({{(EW-SW){1'b0}}, s});
		nxt.lz.p = -signed'({{(EW-SW){1'b0}}, s});
		nxt.lz.m = '0;
		nxt.lo.e = (signed'({{(EW-SW){1'b0}}, sqo_s1}) <<< (2 * FB + 2))
			- signed'({{(EW-SW){1'b0}}, s});
		nxt.lo.p = nxt.lz.p;
		nxt.lo.m = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= nxt;
		end
	end

	always_comb begin
		beat = beat_q;
		beat.vld = vld_q;
	end
endmodule

### rtl/core/tnb_cell.sv
// One cell of the normalisation chain: settles one quotient bit per lane.
module tnb_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [tnb_pkg::BW-1:0] bit_idx,
	input  tnb_pkg::beat_t d,
	output tnb_pkg::beat_t q
);
	import tnb_pkg::*;

	logic signed [EW-1:0] sx;
	lane_t nz, no;
	beat_t nq, beat_q;
	logic vld_q;

	assign sx = signed'({{(EW-SW){1'b0}}, d.s});

	function automatic lane_t step(lane_t l, logic signed [EW-1:0] sv,
			logic [BW-1:0] b);
		logic signed [EW-1:0] dd;
		lane_t r;
		dd = (l.p <<< (b + 2)) + (sv <<< (2 * b + 2));
		r = l;
		if (l.e >= dd) begin
			r.e = l.e - dd;
			r.p = l.p + (sv <<< (b + 1));
			r.m = l.m | (MW'(1) << b);
		end
		return r;
	endfunction

	assign nz = step(d.lz, sx, bit_idx);
	assign no = step(d.lo, sx, bit_idx);

	always_comb begin
		nq = d;
		nq.lz = nz;
		nq.lo = no;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= nq;
		end
	end

	always_comb begin
		q = beat_q;
		q.vld = vld_q;
	end
endmodule

### rtl/core/tnb_back.sv
// Back end: signed tangent, cross products, rounding, saturation, output register.
module tnb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  tnb_pkg::beat_t d,
	output logic vld,
	output logic signed [tnb_pkg::NW-1:0] t0x,
	output logic signed [tnb_pkg::NW-1:0] t0y,
	output logic signed [tnb_pkg::NW-1:0] t0z,
	output logic signed [tnb_pkg::NW-1:0] t1x,
	output logic signed [tnb_pkg::NW-1:0] t1y,
	output logic signed [tnb_pkg::NW-1:0] t1z,
	output logic deg
);
	import tnb_pkg::*;

	localparam int TW = MW + 1;
	localparam int PW = NW + TW;

	logic signed [TW-1:0] mz, mo, a, b, c;
	logic signed [TW-1:0] a_s1, b_s1, c_s1;
	logic signed [PW-1:0] p1, p2, p3, p4;
	logic signed [PW-1:0] p1_s1, p2_s1, p3_s1, p4_s1;
	logic vld_s1, sel_s1, deg_s1;
	logic signed [PW:0] v0, v1, v2;

	function automatic logic signed [NW-1:0] sat(logic signed [PW:0] v);
		if (v > (PW+1)'(32767)) return NW'(32767);
		if (v < -(PW+1)'(32768)) return NW'(-32768);
		return v[NW-1:0];
	endfunction

	function automatic logic signed [PW:0] rnd(logic signed [PW:0] v);
		logic [PW:0] mg;
		mg = v[PW] ? unsigned'(-v) : unsigned'(v);
		mg = (mg + ((PW+1)'(1) << (FB - 1))) >> FB;
		return v[PW] ? -signed'(mg) : signed'(mg);
	endfunction

	assign mz = d.z[NW-1] ? -signed'({1'b0, d.lz.m}) : signed'({1'b0, d.lz.m});
	assign mo = d.sel ? (d.x[NW-1] ? -signed'({1'b0, d.lo.m}) : signed'({1'b0, d.lo.m}))
		: (d.y[NW-1] ? -signed'({1'b0, d.lo.m}) : signed'({1'b0, d.lo.m}));

	always_comb begin
		a = '0;
		b = '0;
		c = '0;
		if (d.sel) begin
			a = mz;
			c = -mo;
		end else begin
			b = -mz;
			c = mo;
		end
		p1 = d.sel ? d.y * a : d.y * c;
		p2 = d.sel ? d.z * a : d.z * b;
		p3 = d.x * c;
		p4 = d.x * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.vld;
			vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a;
			b_s1 <= b;
			c_s1 <= c;
			p1_s1 <= p1;
			p2_s1 <= p2;
			p3_s1 <= p3;
			p4_s1 <= p4;
			sel_s1 <= d.sel;
			deg_s1 <= d.deg;
		end
	end

	always_comb begin
		if (sel_s1) begin
			v0 = rnd((PW+1)'(p1_s1));
			v1 = rnd((PW+1)'(p2_s1) - (PW+1)'(p3_s1));
			v2 = rnd(-(PW+1)'(p1_s1));
		end else begin
			v0 = rnd((PW+1)'(p1_s1) - (PW+1)'(p2_s1));
			v1 = rnd(-(PW+1)'(p3_s1));
			v2 = rnd((PW+1)'(p4_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg <= deg_s1;
			t0x <= deg_s1 ? '0 : sat((PW+1)'(a_s1));
			t0y <= deg_s1 ? '0 : sat((PW+1)'(b_s1));
			t0z <= deg_s1 ? '0 : sat((PW+1)'(c_s1));
			t1x <= deg_s1 ? '0 : sat(v0);
			t1y <= deg_s1 ? '0 : sat(v1);
			t1z <= deg_s1 ? '0 : sat(v2);
		end
	end
endmodule

### rtl/core/contact_tangent_basis_top.sv
// Contact tangent basis: two unit tangents from a contact normal.
// Throughput: one beat per cycle while not stalled; one chain cell settles one normalisation bit.
// The whole pipeline advances unless the output register is full and stalled.
// Reset clears all valid flags; payload registers are not reset.
module contact_tangent_basis_top (
	input  logic clk,
	input  logic arst_n,
	input  logic norm_valid,
	output logic norm_stall,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic basis_valid,
	input  logic basis_stall,
	output logic signed [15:0] first_tangent_x,
	output logic signed [15:0] first_tangent_y,
	output logic signed [15:0] first_tangent_z,
	output logic signed [15:0] second_tangent_x,
	output logic signed [15:0] second_tangent_y,
	output logic signed [15:0] second_tangent_z,
	output logic degenerate_normal
);
	import tnb_pkg::*;

	logic en;
	beat_t chain [NCELL+1];

	assign en = !(basis_valid && basis_stall);
	assign norm_stall = !en;

	tnb_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(norm_valid),
		.x(normal_x), .y(normal_y), .z(normal_z), .beat(chain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		tnb_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .bit_idx(BW'(FB - i)),
			.d(chain[i]), .q(chain[i+1])
		);
	end

	tnb_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .d(chain[NCELL]), .vld(basis_valid),
		.t0x(first_tangent_x), .t0y(first_tangent_y), .t0z(first_tangent_z),
		.t1x(second_tangent_x), .t1y(second_tangent_y), .t1z(second_tangent_z),
		.deg(degenerate_normal)
	);

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && degenerate_normal |-> first_tangent_x == 0 && first_tangent_y == 0
		&& first_tangent_z == 0 && second_tangent_x == 0 && second_tangent_y == 0
		&& second_tangent_z == 0) else $error("degenerate beat with nonzero tangent");

	a_one_zero: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid |-> first_tangent_x == 0 || first_tangent_y == 0)
		else $error("first tangent has no zero component");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!basis_valid |-> !norm_stall) else $error("input stalled with empty output");
endmodule
